@@ rtl/mdm_pkg.sv @@
// Shared constants, codes and the servo duty table of the mecanum drive mixer.
package mdm_pkg;

    // Fixed point and duty ranges
    localparam int FRACTION_BITS  = 14;
    localparam int ONE            = 1 << FRACTION_BITS;
    localparam int MOTOR_DUTY_MAX = 1023;
    localparam int SERVO_DUTY_MAX = 16383;

    // Field widths
    localparam int VEL_W   = 16;                      // velocity fields, signed
    localparam int SPD_W   = 15;                      // key speeds and dead band
    localparam int TMO_W   = 16;
    localparam int ELEV_W  = 8;
    localparam int KEY_W   = 8;
    localparam int DIR_W   = 2;
    localparam int DUTY_W  = 10;
    localparam int SERVO_W = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Mix magnitude (up to three times ONE) and divider quotient
    localparam int MIX_W = VEL_W + 2;                  // signed sum of three
    localparam int MAG_W = $clog2(3 * ONE + 1);
    localparam int QUO_W = FRACTION_BITS + 2;          // quotient <= ONE, radix 4
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int STEP_W  = $clog2(DIV_STEPS);
    localparam int LOW_W   = QUO_W - FRACTION_BITS;    // dividend bits above the fraction

    // Motor duty product
    localparam int PROD_W = MAG_W + DUTY_W;

    // Elevation
    localparam int ELEV_MAX   = 180;
    localparam int ELEV_RESET = 90;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd3;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET  = 16'd220;
    localparam logic [SPD_W-1:0] KEY_LIN_RESET  = 15'd9830;
    localparam logic [SPD_W-1:0] KEY_ROT_RESET  = 15'd7373;
    localparam logic [SPD_W-1:0] DEADBAND_RESET = 15'd164;

    // Request opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_NUMERIC = 2'd1;
    localparam logic [1:0] OP_KEY     = 2'd2;

    // Wheel direction codes
    localparam logic [DIR_W-1:0] DIR_COAST = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

    // Key codes, upper case
    localparam logic [KEY_W-1:0] KEY_W_UP = 8'h57;
    localparam logic [KEY_W-1:0] KEY_S_UP = 8'h53;
    localparam logic [KEY_W-1:0] KEY_A_UP = 8'h41;
    localparam logic [KEY_W-1:0] KEY_D_UP = 8'h44;
    localparam logic [KEY_W-1:0] KEY_Q_UP = 8'h51;
    localparam logic [KEY_W-1:0] KEY_E_UP = 8'h45;
    localparam logic [KEY_W-1:0] KEY_X_UP = 8'h58;
    localparam logic [KEY_W-1:0] KEY_LC_A = 8'h61;
    localparam logic [KEY_W-1:0] KEY_LC_Z = 8'h7A;
    localparam logic [KEY_W-1:0] KEY_CASE = 8'h20;

    // Servo duty per degree, built at elaboration
    localparam int SERVO_LUT_N = ELEV_MAX + 1;

    function automatic logic [SERVO_LUT_N*SERVO_W-1:0] servo_lut_build();
        logic [SERVO_LUT_N*SERVO_W-1:0] lut;
        int pulse;
        int duty;
        lut = '0;
        for (int d = 0; d < SERVO_LUT_N; d++) begin
            pulse = 500 + (2000 * d) / 180;
            duty  = (pulse * SERVO_DUTY_MAX) / 20000;
            if (duty > SERVO_DUTY_MAX) begin
                duty = SERVO_DUTY_MAX;
            end
            lut[d*SERVO_W +: SERVO_W] = SERVO_W'(duty);
        end
        return lut;
    endfunction

    localparam logic [SERVO_LUT_N*SERVO_W-1:0] SERVO_LUT = servo_lut_build();

endpackage

@@ rtl/mdm_divider.sv @@
// Radix-4 restoring divider: floor(num * ONE / den), two quotient bits a cycle.
module mdm_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mdm_pkg::MAG_W-1:0] i_num,   // magnitude, num <= den
    input  logic [mdm_pkg::MAG_W-1:0] i_den,
    output logic                      o_done,  // one-cycle pulse
    output logic [mdm_pkg::QUO_W-1:0] o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [mdm_pkg::STEP_W-1:0]        r_step;
    logic [mdm_pkg::MAG_W-1:0]         r_rem;
    logic [mdm_pkg::QUO_W-1:0]         r_num;
    logic [mdm_pkg::QUO_W-1:0]         r_quo;
    logic [mdm_pkg::MAG_W-1:0]         r_den;

    logic [mdm_pkg::MAG_W:0]           t1;
    logic [mdm_pkg::MAG_W:0]           t2;
    logic [mdm_pkg::MAG_W-1:0]         rem1;
    logic [mdm_pkg::MAG_W-1:0]         rem2;
    logic                              q1;
    logic                              q2;

    // Two chained compare-subtract steps
    always_comb begin
        t1   = {r_rem, r_num[mdm_pkg::QUO_W-1]};
        q1   = (t1 >= {1'b0, r_den});
        rem1 = q1 ? mdm_pkg::MAG_W'(t1 - {1'b0, r_den}) : mdm_pkg::MAG_W'(t1);
        t2   = {rem1, r_num[mdm_pkg::QUO_W-2]};
        q2   = (t2 >= {1'b0, r_den});
        rem2 = q2 ? mdm_pkg::MAG_W'(t2 - {1'b0, r_den}) : mdm_pkg::MAG_W'(t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == mdm_pkg::STEP_W'(mdm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend is num << FRACTION_BITS; its top bits seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num >> mdm_pkg::LOW_W;
            r_num <= {i_num[mdm_pkg::LOW_W-1:0], {mdm_pkg::FRACTION_BITS{1'b0}}};
            r_quo <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= rem2;
            r_num <= {r_num[mdm_pkg::QUO_W-3:0], 2'b00};
            r_quo <= {r_quo[mdm_pkg::QUO_W-3:0], q1, q2};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ rtl/mecanum_drive_mixer.sv @@
// Top level of the mecanum drive mixer: command state, sequencer and result register.

// Each request on the slave stream is a one-millisecond tick, a numeric drive
// command or a key command, and yields exactly one result on the master stream.
// The block holds the last command and a saturating millisecond count; the
// result carries the four wheel directions and 10-bit duties, the elevation
// servo duty and the timeout and command-accepted flags. The wheel mix is
// normalised by one shared radix-4 divider, reused for the four wheels in turn
// (per wheel: divider start, waiting on it, wheel update) when the largest
// mix exceeds 1.0; otherwise the wheels are updated without it, and when the
// motors coast (timed out or disabled) they are skipped. s_axis_tready stays
// low from acceptance until the result is loaded. The result sits
// in its own register, so the next request is taken while the last result still
// waits on m_axis_tready; the new result is held back, and the block stays busy,
// until that one has left. Configuration writes are taken at any time, and
// should be made only while the block is idle.
module mecanum_drive_mixer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, lsb up: forward_speed[15:0], strafe_speed[31:16], yaw_rate[47:32],
    // elevation[55:48], motor_enable[56], key_code[64:57], zero pad [71:65]
    input  logic [71:0]                       s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]                        s_axis_tuser,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, lsb up: front_left_dir[1:0], front_right_dir[3:2], rear_left_dir[5:4],
    // rear_right_dir[7:6], front_left_duty[17:8], front_right_duty[27:18],
    // rear_left_duty[37:28], rear_right_duty[47:38], servo_duty[61:48],
    // timeout_flag[62], command_accepted[63]
    output logic [63:0]                       m_axis_tdata,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mdm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mdm_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int VW = mdm_pkg::VEL_W;
    localparam int MW = mdm_pkg::MIX_W;
    localparam int AW = mdm_pkg::MAG_W;

    localparam logic signed [VW-1:0] VEL_POS = VW'(mdm_pkg::ONE);
    localparam logic signed [VW-1:0] VEL_NEG = -VW'(mdm_pkg::ONE);
    localparam logic [AW-1:0]        MAG_ONE = AW'(mdm_pkg::ONE);
    localparam logic [mdm_pkg::SPD_W-1:0] SPD_ONE = mdm_pkg::SPD_W'(mdm_pkg::ONE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_DIV_START,
        S_DIV_WAIT,
        S_WHEEL,
        S_EMIT
    } t_state;

    // Configuration registers
    logic [mdm_pkg::TMO_W-1:0]   r_timeout;
    logic [mdm_pkg::SPD_W-1:0]   r_key_lin;
    logic [mdm_pkg::SPD_W-1:0]   r_key_rot;
    logic [mdm_pkg::SPD_W-1:0]   r_dead_band;

    // Held command
    logic signed [VW-1:0]        r_fwd;
    logic signed [VW-1:0]        r_str;
    logic signed [VW-1:0]        r_yaw;
    logic [mdm_pkg::ELEV_W-1:0]  r_elev;
    logic                        r_enable;
    logic [mdm_pkg::TMO_W-1:0]   r_ms;

    // Sequencer and per-request working registers
    t_state                      r_state;
    logic                        r_accepted;
    logic                        r_tmo;
    logic                        r_need_div;
    logic [AW-1:0]               r_max;
    logic [AW-1:0]               r_abs  [4];
    logic                        r_neg  [4];
    logic [1:0]                  r_wheel;
    logic [mdm_pkg::DIR_W-1:0]   r_dir  [4];
    logic [mdm_pkg::DUTY_W-1:0]  r_duty [4];
    logic                        r_out_valid;
    logic [63:0]                 r_out_data;

    // Request decode
    logic                        req_take;
    logic [1:0]                  req_op;
    logic signed [VW-1:0]        req_fwd;
    logic signed [VW-1:0]        req_str;
    logic signed [VW-1:0]        req_yaw;
    logic [mdm_pkg::ELEV_W-1:0]  req_elev;
    logic                        req_en;
    logic [mdm_pkg::KEY_W-1:0]   req_key;
    logic [mdm_pkg::KEY_W-1:0]   key_up;
    logic                        key_known;
    logic [mdm_pkg::SPD_W-1:0]   lin_sat;
    logic [mdm_pkg::SPD_W-1:0]   rot_sat;
    logic signed [VW-1:0]        lin_pos;
    logic signed [VW-1:0]        rot_pos;

    // Mix
    logic signed [MW-1:0]        mix   [4];
    logic [AW-1:0]               mix_abs [4];
    logic [AW-1:0]               mix_max;

    // Divider
    logic                        div_start;
    logic                        div_done;
    logic [mdm_pkg::QUO_W-1:0]   div_quot;

    // Wheel finish
    logic [AW-1:0]               wheel_mag;
    logic [mdm_pkg::PROD_W-1:0]  wheel_prod;
    logic [mdm_pkg::SERVO_W-1:0] servo_duty;
    logic                        out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign req_take      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign req_op   = s_axis_tuser;
    assign req_fwd  = s_axis_tdata[15:0];
    assign req_str  = s_axis_tdata[31:16];
    assign req_yaw  = s_axis_tdata[47:32];
    assign req_elev = s_axis_tdata[55:48];
    assign req_en   = s_axis_tdata[56];
    assign req_key  = s_axis_tdata[64:57];

    // Case fold and key decode
    always_comb begin
        key_up = req_key;
        if (req_key >= mdm_pkg::KEY_LC_A && req_key <= mdm_pkg::KEY_LC_Z) begin
            key_up = req_key - mdm_pkg::KEY_CASE;
        end
        key_known = (key_up == mdm_pkg::KEY_W_UP) || (key_up == mdm_pkg::KEY_S_UP) ||
                    (key_up == mdm_pkg::KEY_A_UP) || (key_up == mdm_pkg::KEY_D_UP) ||
                    (key_up == mdm_pkg::KEY_Q_UP) || (key_up == mdm_pkg::KEY_E_UP) ||
                    (key_up == mdm_pkg::KEY_X_UP);
        lin_sat = (r_key_lin > SPD_ONE) ? SPD_ONE : r_key_lin;
        rot_sat = (r_key_rot > SPD_ONE) ? SPD_ONE : r_key_rot;
        lin_pos = {1'b0, lin_sat};
        rot_pos = {1'b0, rot_sat};
    end

    function automatic logic signed [VW-1:0] clamp_vel(input logic signed [VW-1:0] v);
        if (v > VEL_POS) begin
            return VEL_POS;
        end else if (v < VEL_NEG) begin
            return VEL_NEG;
        end
        return v;
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= mdm_pkg::TIMEOUT_RESET;
            r_key_lin   <= mdm_pkg::KEY_LIN_RESET;
            r_key_rot   <= mdm_pkg::KEY_ROT_RESET;
            r_dead_band <= mdm_pkg::DEADBAND_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mdm_pkg::REG_TIMEOUT:  r_timeout   <= i_cfg_data;
                mdm_pkg::REG_KEY_LIN:  r_key_lin   <= i_cfg_data[mdm_pkg::SPD_W-1:0];
                mdm_pkg::REG_KEY_ROT:  r_key_rot   <= i_cfg_data[mdm_pkg::SPD_W-1:0];
                mdm_pkg::REG_DEADBAND: r_dead_band <= i_cfg_data[mdm_pkg::SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // Held command and millisecond count, updated on the accepting edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd      <= '0;
            r_str      <= '0;
            r_yaw      <= '0;
            r_elev     <= mdm_pkg::ELEV_W'(mdm_pkg::ELEV_RESET);
            r_enable   <= 1'b0;
            r_ms       <= '0;
            r_accepted <= 1'b0;
        end else if (req_take) begin
            r_accepted <= 1'b0;
            case (req_op)
                mdm_pkg::OP_TICK: begin
                    if (r_ms != '1) begin
                        r_ms <= r_ms + 1'b1;
                    end
                end
                mdm_pkg::OP_NUMERIC: begin
                    r_fwd      <= clamp_vel(req_fwd);
                    r_str      <= clamp_vel(req_str);
                    r_yaw      <= clamp_vel(req_yaw);
                    r_elev     <= (req_elev > mdm_pkg::ELEV_W'(mdm_pkg::ELEV_MAX)) ?
                                  mdm_pkg::ELEV_W'(mdm_pkg::ELEV_MAX) : req_elev;
                    r_enable   <= req_en;
                    r_ms       <= '0;
                    r_accepted <= 1'b1;
                end
                mdm_pkg::OP_KEY: begin
                    if (key_known) begin
                        r_fwd      <= (key_up == mdm_pkg::KEY_W_UP) ? lin_pos :
                                      (key_up == mdm_pkg::KEY_S_UP) ? -lin_pos : '0;
                        r_str      <= (key_up == mdm_pkg::KEY_A_UP) ? lin_pos :
                                      (key_up == mdm_pkg::KEY_D_UP) ? -lin_pos : '0;
                        r_yaw      <= (key_up == mdm_pkg::KEY_Q_UP) ? rot_pos :
                                      (key_up == mdm_pkg::KEY_E_UP) ? -rot_pos : '0;
                        r_enable   <= (key_up != mdm_pkg::KEY_X_UP);
                        r_ms       <= '0;
                        r_accepted <= 1'b1;
                    end
                end
                default: ;  // unused opcode: ignored
            endcase
        end
    end

    // Wheel mixes from the held command: FL, FR, RL, RR
    always_comb begin
        logic signed [MW-1:0] vx;
        logic signed [MW-1:0] vy;
        logic signed [MW-1:0] wz;
        vx = MW'(r_fwd);
        vy = MW'(r_str);
        wz = MW'(r_yaw);
        mix[0] = vx + vy + wz;
        mix[1] = vx - vy - wz;
        mix[2] = vx - vy + wz;
        mix[3] = vx + vy - wz;
        mix_max = MAG_ONE;
        for (int i = 0; i < 4; i++) begin
            mix_abs[i] = mix[i][MW-1] ? AW'(-mix[i]) : AW'(mix[i]);
            if (mix_abs[i] > mix_max) begin
                mix_max = mix_abs[i];
            end
        end
    end

    assign div_start = (r_state == S_DIV_START) && r_need_div;

    mdm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_abs[r_wheel]),
        .i_den   (r_max),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Normalised magnitude to duty: floor(a * MOTOR_DUTY_MAX / ONE)
    always_comb begin
        wheel_mag  = r_need_div ? AW'(div_quot) : r_abs[r_wheel];
        wheel_prod = mdm_pkg::PROD_W'(wheel_mag) *
                     mdm_pkg::PROD_W'(mdm_pkg::MOTOR_DUTY_MAX);
    end

    assign servo_duty = mdm_pkg::SERVO_LUT[int'(r_elev) * mdm_pkg::SERVO_W +: mdm_pkg::SERVO_W];
    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wheel     <= '0;
        end else begin
            if (r_out_valid && m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_wheel <= '0;
                    if ((r_ms > r_timeout) || !r_enable) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIV_START;
                    end
                end
                S_DIV_START: begin
                    r_state <= r_need_div ? S_DIV_WAIT : S_WHEEL;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= S_WHEEL;
                    end
                end
                S_WHEEL: begin
                    if (r_wheel == 2'd3) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_wheel <= r_wheel + 1'b1;
                        r_state <= S_DIV_START;
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Working data
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MIX: begin
                r_tmo      <= (r_ms > r_timeout);
                r_need_div <= (mix_max > MAG_ONE);
                r_max      <= mix_max;
                for (int i = 0; i < 4; i++) begin
                    r_abs[i]  <= mix_abs[i];
                    r_neg[i]  <= mix[i][MW-1];
                    r_dir[i]  <= mdm_pkg::DIR_COAST;
                    r_duty[i] <= '0;
                end
            end
            S_WHEEL: begin
                // dead band: coast unless magnitude exceeds it
                if (wheel_mag > AW'(r_dead_band)) begin
                    r_dir[r_wheel]  <= r_neg[r_wheel] ? mdm_pkg::DIR_REV : mdm_pkg::DIR_FWD;
                    r_duty[r_wheel] <= wheel_prod[mdm_pkg::FRACTION_BITS +: mdm_pkg::DUTY_W];
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    r_out_data <= {r_accepted, r_tmo, servo_duty,
                                   r_duty[3], r_duty[2], r_duty[1], r_duty[0],
                                   r_dir[3], r_dir[2], r_dir[1], r_dir[0]};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ bench/tb_mecanum_drive_mixer.sv @@
`timescale 1ns / 1ps
// Self-checking bench for mecanum_drive_mixer: directed and random requests, inline predictor.
module tb_mecanum_drive_mixer;
    import mdm_pkg::*;

    // Opcode 3 has no meaning in the block; it must be ignored like an unknown key
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int IDLE_PCT       = 17;     // chance in a hundred of a gap or stall
    localparam int SETTLE_CYCLES  = 60;     // longest request, plus margin
    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no handshake on any channel
    localparam int MAX_REPORTS    = 40;     // mismatch lines printed before going quiet
    localparam int CNT_MAX        = 65535;  // ms counter saturation point

    // Result layout, msb first so that the packed form matches m_axis_tdata
    typedef struct packed {
        logic                   accepted;
        logic                   tmo_flag;
        logic [SERVO_W-1:0]     servo;
        logic [3:0][DUTY_W-1:0] duty;   // [0] front left .. [3] rear right
        logic [3:0][DIR_W-1:0]  dir;
    } t_drive_result;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [71:0]          s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [63:0]          m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // ------------------------------------------------------------------
    // Predictor state: held command, ms counter and register copies
    // ------------------------------------------------------------------
    int cmd_fwd;
    int cmd_str;
    int cmd_yaw;
    int cmd_elev;
    bit cmd_en;
    int ms_idle;
    int lim_timeout;
    int spd_lin;
    int spd_rot;
    int band;

    t_drive_result results_due[$];   // one per accepted request, oldest first
    t_drive_result want;
    t_drive_result got;

    bit tx_idle_en;
    bit rx_stall_en;
    int mismatches;
    int quiet_cycles;

    mecanum_drive_mixer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int clamp_unit(int v);
        if (v > ONE) begin
            return ONE;
        end
        if (v < -ONE) begin
            return -ONE;
        end
        return v;
    endfunction

    // Updates the held command for one request and returns the result it yields
    function automatic t_drive_result predict_wheel_outputs(logic [1:0] op, logic [71:0] d);
        t_drive_result    r;
        logic [KEY_W-1:0] key;
        int               lin;
        int               rot;
        int               pulse;
        int               servo;
        longint           mix [4];
        longint           mag;
        longint           peak;
        r   = '0;
        lin = clamp_unit(spd_lin);   // key speeds above 1.0 saturate
        rot = clamp_unit(spd_rot);
        case (op)
            OP_TICK: begin
                if (ms_idle < CNT_MAX) begin
                    ms_idle++;
                end
            end
            OP_NUMERIC: begin
                cmd_fwd  = clamp_unit(int'($signed(d[15:0])));
                cmd_str  = clamp_unit(int'($signed(d[31:16])));
                cmd_yaw  = clamp_unit(int'($signed(d[47:32])));
                cmd_elev = int'(d[55:48]);
                if (cmd_elev > ELEV_MAX) begin
                    cmd_elev = ELEV_MAX;
                end
                cmd_en     = d[56];
                ms_idle    = 0;
                r.accepted = 1'b1;
            end
            OP_KEY: begin
                key = d[64:57];
                if (key >= KEY_LC_A && key <= KEY_LC_Z) begin
                    key = key - KEY_CASE;
                end
                if (key inside {KEY_W_UP, KEY_S_UP, KEY_A_UP, KEY_D_UP,
                                KEY_Q_UP, KEY_E_UP, KEY_X_UP}) begin
                    cmd_fwd = 0;
                    cmd_str = 0;
                    cmd_yaw = 0;
                    cmd_en  = 1'b1;
                    case (key)
                        KEY_W_UP: cmd_fwd = lin;
                        KEY_S_UP: cmd_fwd = -lin;
                        KEY_A_UP: cmd_str = lin;
                        KEY_D_UP: cmd_str = -lin;
                        KEY_Q_UP: cmd_yaw = rot;
                        KEY_E_UP: cmd_yaw = -rot;
                        default:  cmd_en  = 1'b0;   // stop key
                    endcase
                    ms_idle    = 0;
                    r.accepted = 1'b1;
                end
            end
            default: ;
        endcase

        r.tmo_flag = (ms_idle > lim_timeout);

        if (!r.tmo_flag && cmd_en) begin
            mix[0] = cmd_fwd + cmd_str + cmd_yaw;
            mix[1] = cmd_fwd - cmd_str - cmd_yaw;
            mix[2] = cmd_fwd - cmd_str + cmd_yaw;
            mix[3] = cmd_fwd + cmd_str - cmd_yaw;
            peak = ONE;
            for (int i = 0; i < 4; i++) begin
                mag = (mix[i] < 0) ? -mix[i] : mix[i];
                if (mag > peak) begin
                    peak = mag;
                end
            end
            for (int i = 0; i < 4; i++) begin
                mag = (mix[i] < 0) ? -mix[i] : mix[i];
                if (peak > ONE) begin
                    mag = (mag * ONE) / peak;
                end
                if (mag > band) begin
                    r.dir[i]  = (mix[i] < 0) ? DIR_REV : DIR_FWD;
                    r.duty[i] = DUTY_W'((mag * MOTOR_DUTY_MAX) >>> FRACTION_BITS);
                end
            end
        end

        pulse = 500 + (2000 * cmd_elev) / 180;
        servo = (pulse * SERVO_DUTY_MAX) / 20000;
        if (servo > SERVO_DUTY_MAX) begin
            servo = SERVO_DUTY_MAX;
        end
        r.servo = SERVO_W'(servo);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request helpers
    // ------------------------------------------------------------------
    function automatic logic [71:0] pack_request(logic [15:0] fwd, logic [15:0] str,
                                                 logic [15:0] yaw, logic [7:0] elev,
                                                 logic en, logic [7:0] key);
        return {7'b0, key, en, elev, yaw, str, fwd};
    endfunction

    function automatic logic [71:0] noise_fields();
        return pack_request(16'($urandom), 16'($urandom), 16'($urandom),
                            8'($urandom), 1'($urandom), 8'($urandom));
    endfunction

    // Valid is left high after acceptance so back-to-back requests need no
    // second assignment in the same step; a gap or a drain lowers it.
    task automatic send_request(input logic [1:0] op, input logic [71:0] data);
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        results_due.push_back(predict_wheel_outputs(op, data));
    endtask

    task automatic send_tick();
        send_request(OP_TICK, noise_fields());
    endtask

    task automatic send_numeric(input logic [15:0] fwd, input logic [15:0] str,
                                input logic [15:0] yaw, input logic [7:0] elev,
                                input logic en);
        send_request(OP_NUMERIC, pack_request(fwd, str, yaw, elev, en, 8'($urandom)));
    endtask

    task automatic send_key(input logic [7:0] key);
        send_request(OP_KEY, pack_request(16'($urandom), 16'($urandom), 16'($urandom),
                                          8'($urandom), 1'($urandom), key));
    endtask

    // Lowers valid and holds off until every result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_TIMEOUT:  lim_timeout = int'(value);
            REG_KEY_LIN:  spd_lin     = int'(value[SPD_W-1:0]);
            REG_KEY_ROT:  spd_rot     = int'(value[SPD_W-1:0]);
            REG_DEADBAND: band        = int'(value[SPD_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_all_registers(input logic [15:0] tmo, input logic [15:0] lin,
                                     input logic [15:0] rot, input logic [15:0] db);
        write_register(REG_TIMEOUT, tmo);
        write_register(REG_KEY_LIN, lin);
        write_register(REG_KEY_ROT, rot);
        write_register(REG_DEADBAND, db);
    endtask

    // Velocity mix: mostly in range, some out of range, full scale, near the dead band or zero
    function automatic logic [15:0] rand_velocity();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
            6:                return 16'($urandom);
            7:                return $urandom_range(0, 1) ? 16'(ONE) : 16'(-ONE);
            8:                return 16'(int'($urandom_range(0, 600)) - 300);
            default:          return 16'd0;
        endcase
    endfunction

    function automatic logic [7:0] rand_key();
        logic [7:0] k;
        case ($urandom_range(0, 6))
            0:       k = KEY_W_UP;
            1:       k = KEY_S_UP;
            2:       k = KEY_A_UP;
            3:       k = KEY_D_UP;
            4:       k = KEY_Q_UP;
            5:       k = KEY_E_UP;
            default: k = KEY_X_UP;
        endcase
        if ($urandom_range(0, 1) == 1) begin
            k = k + KEY_CASE;   // lower case
        end
        if ($urandom_range(0, 99) < 15) begin
            k = 8'($urandom);   // mostly unknown keys
        end
        return k;
    endfunction

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_tick();
        end else if (pick < 70) begin
            send_numeric(rand_velocity(), rand_velocity(), rand_velocity(),
                         8'($urandom), 1'($urandom_range(0, 99) < 80));
        end else if (pick < 95) begin
            send_key(rand_key());
        end else begin
            send_request(OP_SPARE, noise_fields());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Motors disabled from reset; servo sits at the reset elevation
    task automatic test_reset_state();
        send_tick();
        send_tick();
    endtask

    task automatic test_numeric_extremes();
        send_numeric(16'(ONE), 16'd0, 16'd0, 8'd0, 1'b1);          // all wheels full
        send_numeric(16'(ONE), 16'(ONE), 16'(ONE), 8'd180, 1'b1);  // peak 3.0, normalised
        send_numeric(16'h7FFF, 16'h8000, 16'h0001, 8'd255, 1'b1);  // clamped inputs
        send_numeric(16'(-ONE), 16'(-ONE), 16'(-ONE), 8'd181, 1'b1);
        send_numeric(16'd100, 16'd50, 16'(-20), 8'd90, 1'b1);      // three wheels in dead band
        send_numeric(16'd165, 16'd0, 16'd0, 8'd1, 1'b1);           // just over dead band
        send_numeric(16'(ONE), 16'd0, 16'd0, 8'd200, 1'b0);        // disabled
        send_tick();
    endtask

    task automatic test_key_commands();
        send_key(KEY_W_UP);
        send_key(KEY_S_UP + KEY_CASE);
        send_key(KEY_A_UP);
        send_key(KEY_D_UP + KEY_CASE);
        send_key(KEY_Q_UP + KEY_CASE);
        send_key(KEY_E_UP);
        send_key(KEY_X_UP + KEY_CASE);
        send_key(KEY_W_UP + KEY_CASE);
        send_key(KEY_LC_Z + 8'd1);     // just past lower case range: unknown
        send_key(8'hFF);               // unknown, state unchanged
        send_request(OP_SPARE, noise_fields());
    endtask

    // Counter passes a small timeout; any command clears it again
    task automatic test_command_timeout();
        write_register(REG_TIMEOUT, 16'd3);
        send_numeric(16'(ONE / 2), 16'd0, 16'd0, 8'd45, 1'b1);
        repeat (5) send_tick();
        send_key(KEY_Q_UP);
        write_register(REG_TIMEOUT, 16'd0);
        send_key(KEY_W_UP);
        send_tick();
    endtask

    // Random phases across register settings, the extremes among them
    task automatic test_random_settings();
        set_all_registers(TIMEOUT_RESET, KEY_LIN_RESET, KEY_ROT_RESET, DEADBAND_RESET);
        repeat (80) send_random_request();

        set_all_registers(16'd2, 16'(ONE), 16'd0, 16'd0);
        repeat (80) send_random_request();

        // wide dead band: everything coasts
        set_all_registers(16'hFFFF, 16'd0, 16'(ONE), 16'(ONE));
        repeat (50) send_random_request();

        // top bit of the data is dropped; speeds above 1.0 saturate
        set_all_registers(16'd6, 16'hFFFF, 16'h7FFF, 16'h7FFF);
        repeat (50) send_random_request();
        write_register(REG_DEADBAND, 16'd1);
        repeat (50) send_random_request();

        // hold the sender until the pipe is empty, then carry on
        set_all_registers(16'd40, 16'd12000, 16'd5000, 16'd300);
        repeat (40) send_random_request();
        drain_results();
        repeat (40) send_random_request();
    endtask

    // Long stretch without gaps or stalls on either side
    task automatic test_no_idle_burst();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        repeat (120) send_random_request();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls and the checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= !(rx_stall_en && $urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic string wheel_name(int w);
        case (w)
            0:       return "front_left";
            1:       return "front_right";
            2:       return "rear_left";
            default: return "rear_right";
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input longint exp_v, input longint act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s expected %0d got %0d", $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t ns: result with no request due, expected none got %h",
                             $time, m_axis_tdata);
                end
            end else begin
                want = results_due.pop_front();
                got  = t_drive_result'(m_axis_tdata);
                for (int w = 0; w < 4; w++) begin
                    if (got.dir[w] !== want.dir[w]) begin
                        flag_mismatch({wheel_name(w), "_dir"}, want.dir[w], got.dir[w]);
                    end
                    if (got.duty[w] !== want.duty[w]) begin
                        flag_mismatch({wheel_name(w), "_duty"}, want.duty[w], got.duty[w]);
                    end
                end
                if (got.servo !== want.servo) begin
                    flag_mismatch("servo_duty", want.servo, got.servo);
                end
                if (got.tmo_flag !== want.tmo_flag) begin
                    flag_mismatch("timeout_flag", want.tmo_flag, got.tmo_flag);
                end
                if (got.accepted !== want.accepted) begin
                    flag_mismatch("command_accepted", want.accepted, got.accepted);
                end
            end
        end
    end

    // Watchdog: a stuck handshake on every channel ends the run
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TICK;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_TIMEOUT;
        i_cfg_data    = '0;
        tx_idle_en    = 1'b1;
        rx_stall_en   = 1'b1;
        mismatches    = 0;
        quiet_cycles  = 0;

        // predictor copy of the reset state
        cmd_fwd     = 0;
        cmd_str     = 0;
        cmd_yaw     = 0;
        cmd_elev    = ELEV_RESET;
        cmd_en      = 1'b0;
        ms_idle     = 0;
        lim_timeout = int'(TIMEOUT_RESET);
        spd_lin     = int'(KEY_LIN_RESET);
        spd_rot     = int'(KEY_ROT_RESET);
        band        = int'(DEADBAND_RESET);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_numeric_extremes();
        test_key_commands();
        test_command_timeout();
        test_random_settings();
        test_no_idle_burst();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mdm_pkg.sv
rtl/mdm_divider.sv
rtl/mecanum_drive_mixer.sv
bench/tb_mecanum_drive_mixer.sv
